[hw/rtl/ebl_pkg.sv]
// ebl_pkg: shared constants and codes for the embedding-bag lookup and pool engine.
// No dependencies; imported by the top level.

package ebl_pkg;

   // default sizes of the table, the row and the bag
   localparam int DEF_TABLE_ROWS = 256;
   localparam int DEF_MAX_WIDTH  = 16;
   localparam int DEF_MAX_BAG    = 32;

   // fixed field widths
   localparam int ELEM_W   = 16;
   localparam int ROW_W    = 8;
   localparam int COL_W    = 4;
   localparam int CSR_IDXW = 2;
   localparam int CSR_DW   = 6;
   localparam int LANE_CAP = 16;

   // request function codes
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // pool modes
   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_SUM   = 2'd1;
   localparam logic [1:0] MODE_MEAN  = 2'd2;

   // register indexes on the csr port
   localparam logic [CSR_IDXW-1:0] CSR_POOL_MODE = 2'd0;
   localparam logic [CSR_IDXW-1:0] CSR_BAG_SIZE  = 2'd1;
   localparam logic [CSR_IDXW-1:0] CSR_ROW_WIDTH = 2'd2;

endpackage

[hw/rtl/ebl_ram.sv]
// ebl_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies; used for the embedding table and the column accumulators.

module ebl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata <= mem_ff[raddr];
   end

endmodule

[hw/rtl/ebl_div.sv]
// ebl_div: iterative restoring divider for unsigned magnitudes, one quotient bit a cycle.
// No dependencies; used by the top level for mean pooling.

module ebl_div #(
   parameter int NUM_W = 21,
   parameter int DEN_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = DEN_W'(shifted);
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[hw/rtl/embedding_bag_lookup_pool.sv]
// embedding_bag_lookup_pool: top level of the embedding-bag engine (sequencer and output stage).
// Depends on ebl_pkg, ebl_ram and ebl_div.

// A write word (func 0) stores one signed Q7.8 table element in the accept cycle and never raises
// busy. A lookup word (func 1) adds every column of the addressed row into the per-column
// accumulators: the table RAM has one read port, so a lookup keeps busy high while it reads the
// columns in turn and then writes back the last sum, and the next word is taken in the first
// cycle that busy is low. When the lookup completes a bag, busy stays high while the engine emits
// one result word per column in use, in column order, the final one marked by rsp_last_of_bag;
// each column passes through the read, latch and emit states, and in mean mode also through the
// bit-serial divider. Results are shown for a single cycle under rsp_strobe and cannot be
// held off, so the receiver must take every strobed word. Table entries never written read back
// as unknown values.

module embedding_bag_lookup_pool
   import ebl_pkg::*;
#(
   parameter int TABLE_ROWS = DEF_TABLE_ROWS,
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_BAG    = DEF_MAX_BAG
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_func,
   input  logic [ROW_W-1:0]         req_row_index,
   input  logic [COL_W-1:0]         req_column,
   input  logic signed [ELEM_W-1:0] req_element_value,
   // response channel
   output logic                     rsp_strobe,
   output logic [COL_W-1:0]         rsp_out_column,
   output logic signed [ELEM_W-1:0] rsp_pooled_value,
   output logic                     rsp_clipped,
   output logic                     rsp_last_of_bag,
   // register write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDXW-1:0]      csr_index,
   input  logic [CSR_DW-1:0]        csr_data
);

   localparam int LANES     = (MAX_WIDTH < LANE_CAP) ? MAX_WIDTH : LANE_CAP;
   localparam int LANE_AW   = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int W_W       = $clog2(LANES + 1);
   localparam int BAG_W     = $clog2(MAX_BAG + 1);
   localparam int ACC_W     = ELEM_W + $clog2(MAX_BAG);
   localparam int TBL_DEPTH = TABLE_ROWS * MAX_WIDTH;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);

   localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'(32767);
   localparam logic signed [ACC_W:0] SAT_LO = (ACC_W+1)'(-32768);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_ACC   = 7'b0000010,
      S_ACCWB = 7'b0000100,
      S_ORD   = 7'b0001000,
      S_OLAT  = 7'b0010000,
      S_ODIV  = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   // registers
   state_type          state_ff, state_in;
   logic [1:0]         pool_mode_ff, pool_mode_in;
   logic [5:0]         bag_size_ff, bag_size_in;
   logic [4:0]         row_width_ff, row_width_in;
   logic [BAG_W-1:0]   cnt_ff, cnt_in;
   logic [LANES-1:0]   sum_vld_ff, sum_vld_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               row_ok_ff, row_ok_in;
   logic [LANE_AW-1:0] lane_ff, lane_in;
   logic [LANE_AW-1:0] col_ff, col_in;
   logic               wb_pend_ff, wb_pend_in;
   logic [LANE_AW-1:0] wb_lane_ff, wb_lane_in;
   logic               neg_ff, neg_in;
   logic signed [ACC_W:0] val_ff, val_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [ELEM_W-1:0]  rsp_val_ff, rsp_val_in;
   logic               rsp_clip_ff, rsp_clip_in;
   logic               rsp_last_ff, rsp_last_in;

   // memories and divider hookup
   logic               tbl_we;
   logic [TBL_AW-1:0]  tbl_waddr;
   logic [TBL_AW-1:0]  tbl_raddr;
   logic [ELEM_W-1:0]  tbl_rdata;
   logic               sum_we;
   logic [LANE_AW-1:0] sum_raddr;
   logic [ACC_W-1:0]   sum_wdata;
   logic [ACC_W-1:0]   sum_rdata;
   logic [ACC_W-1:0]   sum_old;
   logic [ACC_W-1:0]   tbl_add;
   logic [ACC_W-1:0]   sum_now;
   logic               div_start;
   logic [ACC_W-1:0]   div_num;
   logic               div_done;
   logic [ACC_W-1:0]   div_quot;

   // effective configuration
   logic [BAG_W-1:0]   eff_bag;
   logic [W_W-1:0]     eff_w;
   logic               mean_mode;
   logic               accept;
   logic               is_last_col;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign mean_mode = (pool_mode_ff >= MODE_MEAN);

   // bag length and row width after clamping
   always_comb begin
      if (pool_mode_ff == MODE_PLAIN || bag_size_ff == 6'd0) begin
         eff_bag = BAG_W'(1);
      end else if (int'(bag_size_ff) > MAX_BAG) begin
         eff_bag = BAG_W'(MAX_BAG);
      end else begin
         eff_bag = BAG_W'(bag_size_ff);
      end
      if (row_width_ff == 5'd0) begin
         eff_w = W_W'(1);
      end else if (int'(row_width_ff) > LANES) begin
         eff_w = W_W'(LANES);
      end else begin
         eff_w = W_W'(row_width_ff);
      end
   end

   // table write at accept, row read during accumulation
   assign tbl_we    = accept && (req_func == FUNC_WRITE) && (int'(req_row_index) < TABLE_ROWS)
                      && (int'(req_column) < LANES);
   assign tbl_waddr = TBL_AW'(int'(req_row_index) * MAX_WIDTH + int'(req_column));
   assign tbl_raddr = TBL_AW'(int'(row_ff) * MAX_WIDTH + int'(lane_ff));

   ebl_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (TBL_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (req_element_value),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   // accumulator write-back in the cycle after the read
   assign sum_old   = sum_vld_ff[wb_lane_ff] ? sum_rdata : '0;
   assign tbl_add   = row_ok_ff ? ACC_W'(signed'(tbl_rdata)) : '0;
   assign sum_wdata = sum_old + tbl_add;
   assign sum_we    = wb_pend_ff;
   assign sum_raddr = (state_ff == S_ACC) ? lane_ff : col_ff;

   ebl_ram #(
      .WIDTH (ACC_W),
      .DEPTH (LANES)
   ) u_sums (
      .clock (clock),
      .we    (sum_we),
      .waddr (wb_lane_ff),
      .wdata (sum_wdata),
      .raddr (sum_raddr),
      .rdata (sum_rdata)
   );

   // mean divides the magnitude, sign restored afterwards
   assign sum_now = sum_vld_ff[col_ff] ? sum_rdata : '0;
   assign div_num = sum_now[ACC_W-1] ? ACC_W'(-sum_now) : sum_now;

   ebl_div #(
      .NUM_W (ACC_W),
      .DEN_W (BAG_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (eff_bag),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign is_last_col = ((int'(col_ff) + 1) == int'(eff_w));

   // register writes
   always_comb begin
      pool_mode_in = pool_mode_ff;
      bag_size_in  = bag_size_ff;
      row_width_in = row_width_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_POOL_MODE: pool_mode_in = csr_data[1:0];
            CSR_BAG_SIZE:  bag_size_in  = csr_data[5:0];
            CSR_ROW_WIDTH: row_width_in = csr_data[4:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      sum_vld_in    = sum_vld_ff;
      row_in        = row_ff;
      row_ok_in     = row_ok_ff;
      lane_in       = lane_ff;
      col_in        = col_ff;
      wb_pend_in    = 1'b0;
      wb_lane_in    = wb_lane_ff;
      neg_in        = neg_ff;
      val_in        = val_ff;
      div_start     = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_col_in    = rsp_col_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_clip_in   = rsp_clip_ff;
      rsp_last_in   = rsp_last_ff;

      if (sum_we) begin
         sum_vld_in[wb_lane_ff] = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_func == FUNC_LOOKUP) begin
               row_in    = req_row_index;
               row_ok_in = (int'(req_row_index) < TABLE_ROWS);
               lane_in   = '0;
               state_in  = S_ACC;
            end
         end
         S_ACC: begin
            wb_pend_in = 1'b1;
            wb_lane_in = lane_ff;
            if (lane_ff == LANE_AW'(LANES - 1)) begin
               state_in = S_ACCWB;
            end else begin
               lane_in = lane_ff + LANE_AW'(1);
            end
         end
         S_ACCWB: begin
            cnt_in = cnt_ff + BAG_W'(1);
            if ((cnt_ff + BAG_W'(1)) >= eff_bag) begin
               col_in   = '0;
               state_in = S_ORD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ORD: begin
            state_in = S_OLAT;
         end
         S_OLAT: begin
            if (mean_mode) begin
               neg_in    = sum_now[ACC_W-1];
               div_start = 1'b1;
               state_in  = S_ODIV;
            end else begin
               val_in   = (ACC_W+1)'(signed'(sum_now));
               state_in = S_EMIT;
            end
         end
         S_ODIV: begin
            if (div_done) begin
               val_in   = neg_ff ? -signed'({1'b0, div_quot}) : signed'({1'b0, div_quot});
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_col_in    = COL_W'(col_ff);
            rsp_last_in   = is_last_col;
            if (val_ff > SAT_HI) begin
               rsp_val_in  = 16'h7FFF;
               rsp_clip_in = 1'b1;
            end else if (val_ff < SAT_LO) begin
               rsp_val_in  = 16'h8000;
               rsp_clip_in = 1'b1;
            end else begin
               rsp_val_in  = val_ff[ELEM_W-1:0];
               rsp_clip_in = 1'b0;
            end
            if (is_last_col) begin
               sum_vld_in = '0;
               cnt_in     = '0;
               state_in   = S_IDLE;
            end else begin
               col_in   = col_ff + LANE_AW'(1);
               state_in = S_ORD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pool_mode_ff  <= MODE_PLAIN;
         bag_size_ff   <= 6'd1;
         row_width_ff  <= 5'd16;
         cnt_ff        <= '0;
         sum_vld_ff    <= '0;
         wb_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pool_mode_ff  <= pool_mode_in;
         bag_size_ff   <= bag_size_in;
         row_width_ff  <= row_width_in;
         cnt_ff        <= cnt_in;
         sum_vld_ff    <= sum_vld_in;
         wb_pend_ff    <= wb_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      row_ff      <= row_in;
      row_ok_ff   <= row_ok_in;
      lane_ff     <= lane_in;
      col_ff      <= col_in;
      wb_lane_ff  <= wb_lane_in;
      neg_ff      <= neg_in;
      val_ff      <= val_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_clip_ff <= rsp_clip_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_out_column   = rsp_col_ff;
   assign rsp_pooled_value = signed'(rsp_val_ff);
   assign rsp_clipped      = rsp_clip_ff;
   assign rsp_last_of_bag  = rsp_last_ff;

   // write-back never hits the accumulator being read in the same cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC && wb_pend_ff) |-> (wb_lane_ff != lane_ff))
      else $error("accumulator read and write-back collide");

   // a result word only follows an emit cycle
   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_EMIT))
      else $error("result strobe without emit");

   // bag count stays within the largest bag
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= BAG_W'(MAX_BAG))
      else $error("bag count out of range");

   // accumulators and count are cleared with the final word of a bag
   a_bag_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_of_bag) |-> (cnt_ff == '0 && sum_vld_ff == '0))
      else $error("bag state not cleared after final word");

endmodule
